FILE: src/bba_pkg.sv
// Package for the buddy block allocator: field widths, command and status codes,
// and the sequencer state type. No dependencies.
package bba_pkg;

  localparam int unsigned REQ_W       = 24;
  localparam int unsigned NODE_IN_W   = 9;
  localparam int unsigned LEVEL_OUT_W = 4;
  localparam int unsigned OFFSET_W    = 24;
  localparam int unsigned NLEV_W      = 4;
  localparam int unsigned BUCKET_W    = 16;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned CFG_ADDR_W  = 1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_SPACE = 2'd1,
    STS_TOO_BIG  = 2'd2,
    STS_BAD_NODE = 2'd3
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NUM_LEVELS = 1'b0,
    REG_MIN_BUCKET = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_LVL,
    S_A_SCAN,
    S_A_TAKE,
    S_A_SPR,
    S_A_SPL,
    S_A_OFS,
    S_F_RD,
    S_F_CHK,
    S_F_UP,
    S_F_BUD,
    S_F_CLR,
    S_RESP
  } state_t;

endpackage

FILE: src/bba_map.sv
// Free-block bitmap storage: one bit per tree node, one write and one read
// port, registered read data. No dependencies.
module bba_map #(
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/buddy_block_allocator.sv
// Buddy block allocator top level: stream channels, config registers, sequencer.
// Depends on bba_pkg and bba_map.
//
// Usage: an allocate or free request enters on the in_ channel (in_tuser selects
// the command). Exactly one result per request leaves on the out_ channel with a
// status in out_tuser. One request is worked at a time; in_tready is high only
// when the sequencer is idle. The free map is a bit memory with one write and one
// read port.
// Allocate: descend to the deepest level that fits, scan its nodes (trying shallower
// levels if none is free), take the block and split it down; the scan of a level dominates.
// Free: check the node, then merge buddy pairs upward while the buddy is free.
// After reset the map is cleared one node per cycle, all 2^(MAX_TREE_LEVELS+1) nodes
// (512 at the default); no request is taken meanwhile, config writes are.
// A finished result waits in the output register until out_tready; the next
// request is taken the cycle after the result is handed over.
// Config writes: cfg_addr 0 is num_levels, 1 is min_bucket_bytes; write only
// while idle.
module buddy_block_allocator #(
  parameter int unsigned MAX_TREE_LEVELS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]         in_tdata,  // request_bytes, node_index
  input  logic                                  in_tuser,  // command
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]        out_tdata, // granted_node, granted_level,
                                                           // block_offset
  output logic [1:0]                            out_tuser, // status
  input  logic                                  cfg_we,
  input  logic [bba_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [bba_pkg::BUCKET_W-1:0]          cfg_wdata
);

  localparam int unsigned NODE_W = MAX_TREE_LEVELS + 1;
  localparam int unsigned LVL_W  = $clog2(MAX_TREE_LEVELS + 1);
  localparam int unsigned MEM_W  = bba_pkg::BUCKET_W + MAX_TREE_LEVELS;
  localparam int unsigned NEED_W = bba_pkg::REQ_W + 1;
  localparam int unsigned CMP_W  = (MEM_W > NEED_W) ? MEM_W : NEED_W;
  localparam int unsigned PROD_W = NODE_W + MEM_W;

  bba_pkg::state_t                state_r, state_nxt;
  logic [bba_pkg::NLEV_W-1:0]     nlev_r;
  logic [bba_pkg::BUCKET_W-1:0]   bucket_r;
  bba_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [bba_pkg::REQ_W-1:0]      req_r, req_nxt;
  logic [bba_pkg::NODE_IN_W-1:0]  node_in_r, node_in_nxt;
  logic [MEM_W-1:0]               blk_r, blk_nxt;
  logic [LVL_W-1:0]               k_r, k_nxt;
  logic [LVL_W-1:0]               j_r, j_nxt;
  logic [NODE_W-1:0]              cur_r, cur_nxt;
  logic [NODE_W:0]                scan_r, scan_nxt;
  logic                           chk_v_r, chk_v_nxt;
  logic [NODE_W-1:0]              clr_r, clr_nxt;
  bba_pkg::status_t               sts_r, sts_nxt;
  logic [bba_pkg::NODE_IN_W-1:0]  gnode_r, gnode_nxt;
  logic [bba_pkg::LEVEL_OUT_W-1:0] glvl_r, glvl_nxt;
  logic [bba_pkg::OFFSET_W-1:0]   ofs_r, ofs_nxt;

  logic                           map_we;
  logic [NODE_W-1:0]              map_waddr;
  logic                           map_wdata;
  logic [NODE_W-1:0]              map_raddr;
  logic                           map_rdata;

  logic [LVL_W-1:0]               eff_l;
  logic [MEM_W-1:0]               mem_bytes;
  logic [CMP_W-1:0]               need_c;
  logic [NODE_W:0]                lvl_end;
  logic [NODE_W-1:0]              idx;
  logic [PROD_W-1:0]              prod;
  logic                           bad_free;

  bba_map #(.ADDR_W(NODE_W)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign eff_l     = (32'(nlev_r) > MAX_TREE_LEVELS) ? LVL_W'(MAX_TREE_LEVELS)
                                                     : LVL_W'(nlev_r);
  assign mem_bytes = MEM_W'(bucket_r) << eff_l;
  assign need_c    = CMP_W'(req_r) + CMP_W'(bba_pkg::HEADER_BYTES);
  assign lvl_end   = (NODE_W+1)'(2) << j_r;
  assign idx       = cur_r - (NODE_W'(1) << k_r);
  assign prod      = PROD_W'(idx) * PROD_W'(blk_r);
  assign bad_free  = (node_in_r == '0) || (32'(node_in_r) >= (32'd2 << eff_l)) || map_rdata;

  assign in_tready  = (state_r == bba_pkg::S_IDLE);
  assign out_tvalid = (state_r == bba_pkg::S_RESP);
  assign out_tuser  = sts_r;
  assign out_tdata  = {3'b000, ofs_r, glvl_r, gnode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlev_r   <= bba_pkg::NLEV_W'(8);
      bucket_r <= bba_pkg::BUCKET_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bba_pkg::REG_NUM_LEVELS: nlev_r   <= cfg_wdata[bba_pkg::NLEV_W-1:0];
        bba_pkg::REG_MIN_BUCKET: bucket_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLEAR;
      clr_r   <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    req_r     <= req_nxt;
    node_in_r <= node_in_nxt;
    blk_r     <= blk_nxt;
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    cur_r     <= cur_nxt;
    scan_r    <= scan_nxt;
    sts_r     <= sts_nxt;
    gnode_r   <= gnode_nxt;
    glvl_r    <= glvl_nxt;
    ofs_r     <= ofs_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    req_nxt     = req_r;
    node_in_nxt = node_in_r;
    blk_nxt     = blk_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    cur_nxt     = cur_r;
    scan_nxt    = scan_r;
    chk_v_nxt   = chk_v_r;
    clr_nxt     = clr_r;
    sts_nxt     = sts_r;
    gnode_nxt   = gnode_r;
    glvl_nxt    = glvl_r;
    ofs_nxt     = ofs_r;
    map_we      = 1'b0;
    map_waddr   = cur_r;
    map_wdata   = 1'b0;
    map_raddr   = cur_r;

    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = (clr_r == NODE_W'(1));
        clr_nxt   = clr_r + NODE_W'(1);
        if (clr_r == '1) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end

      bba_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = bba_pkg::cmd_t'(in_tuser);
          req_nxt     = in_tdata[bba_pkg::REQ_W-1:0];
          node_in_nxt = in_tdata[bba_pkg::REQ_W +: bba_pkg::NODE_IN_W];
          cur_nxt     = NODE_W'(in_tdata[bba_pkg::REQ_W +: bba_pkg::NODE_IN_W]);
          sts_nxt     = bba_pkg::STS_OK;
          gnode_nxt   = '0;
          glvl_nxt    = '0;
          ofs_nxt     = '0;
          state_nxt   = (in_tuser == bba_pkg::CMD_FREE) ? bba_pkg::S_F_RD : bba_pkg::S_A_CHK;
        end
      end

      bba_pkg::S_A_CHK: begin
        blk_nxt = mem_bytes;
        k_nxt   = '0;
        if (need_c > CMP_W'(mem_bytes)) begin
          sts_nxt   = bba_pkg::STS_TOO_BIG;
          state_nxt = bba_pkg::S_RESP;
        end else begin
          state_nxt = bba_pkg::S_A_LVL;
        end
      end

      bba_pkg::S_A_LVL: begin
        if ((k_r < eff_l) && (CMP_W'(blk_r >> 1) >= need_c)) begin
          k_nxt   = k_r + LVL_W'(1);
          blk_nxt = blk_r >> 1;
        end else begin
          j_nxt     = k_r;
          scan_nxt  = (NODE_W+1)'(1) << k_r;
          chk_v_nxt = 1'b0;
          state_nxt = bba_pkg::S_A_SCAN;
        end
      end

      bba_pkg::S_A_SCAN: begin
        map_raddr = scan_r[NODE_W-1:0];
        if (chk_v_r && map_rdata) begin
          cur_nxt   = NODE_W'(scan_r - (NODE_W+1)'(1));
          chk_v_nxt = 1'b0;
          state_nxt = bba_pkg::S_A_TAKE;
        end else if (scan_r < lvl_end) begin
          chk_v_nxt = 1'b1;
          scan_nxt  = scan_r + (NODE_W+1)'(1);
        end else if (chk_v_r) begin
          chk_v_nxt = 1'b0;
        end else if (j_r == '0) begin
          sts_nxt   = bba_pkg::STS_NO_SPACE;
          state_nxt = bba_pkg::S_RESP;
        end else begin
          j_nxt    = j_r - LVL_W'(1);
          scan_nxt = (NODE_W+1)'(1) << (j_r - LVL_W'(1));
        end
      end

      bba_pkg::S_A_TAKE: begin
        map_we    = 1'b1;
        map_waddr = cur_r;
        map_wdata = 1'b0;
        state_nxt = (j_r == k_r) ? bba_pkg::S_A_OFS : bba_pkg::S_A_SPR;
      end

      bba_pkg::S_A_SPR: begin
        map_we    = 1'b1;
        map_waddr = {cur_r[NODE_W-2:0], 1'b1};
        map_wdata = 1'b1;
        state_nxt = bba_pkg::S_A_SPL;
      end

      bba_pkg::S_A_SPL: begin
        map_we    = 1'b1;
        map_waddr = {cur_r[NODE_W-2:0], 1'b0};
        map_wdata = 1'b0;
        cur_nxt   = {cur_r[NODE_W-2:0], 1'b0};
        j_nxt     = j_r + LVL_W'(1);
        state_nxt = ((j_r + LVL_W'(1)) == k_r) ? bba_pkg::S_A_OFS : bba_pkg::S_A_SPR;
      end

      bba_pkg::S_A_OFS: begin
        gnode_nxt = bba_pkg::NODE_IN_W'(cur_r);
        glvl_nxt  = bba_pkg::LEVEL_OUT_W'(k_r);
        ofs_nxt   = bba_pkg::OFFSET_W'(prod);
        state_nxt = bba_pkg::S_RESP;
      end

      bba_pkg::S_F_RD: begin
        map_raddr = cur_r;
        state_nxt = bba_pkg::S_F_CHK;
      end

      bba_pkg::S_F_CHK: begin
        if (bad_free) begin
          sts_nxt   = bba_pkg::STS_BAD_NODE;
          state_nxt = bba_pkg::S_RESP;
        end else begin
          state_nxt = bba_pkg::S_F_UP;
        end
      end

      bba_pkg::S_F_UP: begin
        map_raddr = {cur_r[NODE_W-1:1], ~cur_r[0]};
        if (cur_r == NODE_W'(1)) begin
          map_we    = 1'b1;
          map_waddr = cur_r;
          map_wdata = 1'b1;
          state_nxt = bba_pkg::S_RESP;
        end else begin
          state_nxt = bba_pkg::S_F_BUD;
        end
      end

      bba_pkg::S_F_BUD: begin
        map_we = 1'b1;
        if (map_rdata) begin
          map_waddr = {cur_r[NODE_W-1:1], ~cur_r[0]};
          map_wdata = 1'b0;
          state_nxt = bba_pkg::S_F_CLR;
        end else begin
          map_waddr = cur_r;
          map_wdata = 1'b1;
          state_nxt = bba_pkg::S_RESP;
        end
      end

      bba_pkg::S_F_CLR: begin
        map_we    = 1'b1;
        map_waddr = cur_r;
        map_wdata = 1'b0;
        cur_nxt   = cur_r >> 1;
        state_nxt = bba_pkg::S_F_UP;
      end

      bba_pkg::S_RESP: begin
        if (out_tready) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

endmodule
